// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the RTL folder.
// Each macro expects clk and rst to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== hw/rtl/ddfp_pkg.sv =====
// Package for the delimited decimal frame parser: byte codes, widths,
// operation codes and the default frame buffer size. No dependencies.
package ddfp_pkg;

  localparam int BYTE_W  = 8;
  localparam int VALUE_W = 32;
  localparam int RUN_W   = 31;

  localparam int BUFFER_BYTES_DEF = 16;

  localparam logic [BYTE_W-1:0] BYTE_START = 8'h24;  // '$'
  localparam logic [BYTE_W-1:0] BYTE_END   = 8'h23;  // '#'
  localparam logic [BYTE_W-1:0] BYTE_ZERO  = 8'h30;  // '0'
  localparam logic [BYTE_W-1:0] BYTE_NINE  = 8'h39;  // '9'

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic signed [VALUE_W-1:0] VALUE_NONE = -32'sd1;

endpackage

// ===== hw/rtl/ddfp_rx_if.sv =====
// Input channel of the frame parser: one received byte or a clear request.
// Depends on ddfp_pkg.
interface ddfp_rx_if;
  import ddfp_pkg::*;

  logic              valid;
  logic              ready;
  logic              operation;
  logic [BYTE_W-1:0] rx_data;

  modport source (output valid, operation, rx_data, input ready);
  modport sink   (input valid, operation, rx_data, output ready);
endinterface

// ===== hw/rtl/ddfp_res_if.sv =====
// Result channel of the frame parser: stored value, fresh flag, frame flag.
// Depends on ddfp_pkg.
interface ddfp_res_if;
  import ddfp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] current_value;
  logic                      value_fresh;
  logic                      frame_accepted;

  modport source (output valid, current_value, value_fresh, frame_accepted, input ready);
  modport sink   (input valid, current_value, value_fresh, frame_accepted, output ready);
endinterface

// ===== hw/rtl/delimited_decimal_frame_parser_top.sv =====
// Top level of the delimited decimal frame parser.
// Depends on ddfp_pkg, ddfp_rx_if and ddfp_res_if.
//
// Parses frames of the form '$' digits '#' from a byte stream and keeps the
// last decimal value, -1 until a frame is taken or after a clear request.
// Every transfer on rx produces exactly one transfer on res. The frame state and
// the stored value update at the rx transfer, and the result sits in the output
// register the next cycle. rx is ready whenever the output register is empty or
// is being drained in the same cycle, so the block sustains one item per clock
// while res takes each result. The digit update is a shift-add by ten plus a
// 31-bit overflow check; that path sets the clock limit.
module delimited_decimal_frame_parser_top #(
  parameter int BUFFER_BYTES = ddfp_pkg::BUFFER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ddfp_rx_if.sink     rx,
  ddfp_res_if.source  res
);
  import ddfp_pkg::*;

  localparam int LEN_W = $clog2(BUFFER_BYTES);
  localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(BUFFER_BYTES - 1);

  logic [LEN_W-1:0]          held_length, held_length_next;
  logic [RUN_W-1:0]          running_value, running_value_next;
  logic                      all_digits, all_digits_next;
  logic                      value_overflowed, value_overflowed_next;
  logic signed [VALUE_W-1:0] stored_value, stored_value_next;
  logic                      fresh_flag, fresh_flag_next;
  logic                      accepted_next;
  logic                      frame_accepted;
  logic                      res_valid;
  logic                      take;
  logic                      is_digit;
  logic [RUN_W+3:0]          scaled;

  assign rx.ready = !res_valid || res.ready;
  assign take     = rx.valid && rx.ready;

  assign is_digit = (rx.rx_data >= BYTE_ZERO) && (rx.rx_data <= BYTE_NINE);
  // value * 10 + digit as (v << 3) + (v << 1) + d
  assign scaled = ({1'b0, running_value, 3'b000} + {3'b000, running_value, 1'b0})
                + (RUN_W+4)'(rx.rx_data - BYTE_ZERO);

  always_comb begin
    held_length_next      = held_length;
    running_value_next    = running_value;
    all_digits_next       = all_digits;
    value_overflowed_next = value_overflowed;
    stored_value_next     = stored_value;
    fresh_flag_next       = fresh_flag;
    accepted_next         = 1'b0;

    if (rx.operation == OP_CLEAR) begin
      stored_value_next = VALUE_NONE;
      fresh_flag_next   = 1'b0;
    end else if (rx.rx_data == BYTE_START) begin
      held_length_next      = '0;
      running_value_next    = '0;
      all_digits_next       = 1'b1;
      value_overflowed_next = 1'b0;
    end else if (rx.rx_data == BYTE_END) begin
      if ((held_length != '0) && all_digits && !value_overflowed) begin
        stored_value_next = {1'b0, running_value};
        fresh_flag_next   = 1'b1;
        accepted_next     = 1'b1;
      end
      held_length_next      = '0;
      running_value_next    = '0;
      all_digits_next       = 1'b1;
      value_overflowed_next = 1'b0;
    end else if (held_length < LEN_LAST) begin
      held_length_next = held_length + LEN_W'(1);
      if (!is_digit) begin
        all_digits_next = 1'b0;
      end else if (all_digits && !value_overflowed) begin
        // freeze the value once it would pass 2^31-1
        if (scaled[RUN_W+3:RUN_W] != '0) begin
          value_overflowed_next = 1'b1;
        end else begin
          running_value_next = scaled[RUN_W-1:0];
        end
      end
    end else begin
      // frame full: drop the byte and the frame
      held_length_next      = '0;
      running_value_next    = '0;
      all_digits_next       = 1'b1;
      value_overflowed_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_length      <= '0;
      running_value    <= '0;
      all_digits       <= 1'b1;
      value_overflowed <= 1'b0;
      stored_value     <= VALUE_NONE;
      fresh_flag       <= 1'b0;
      res_valid        <= 1'b0;
    end else begin
      if (take) begin
        held_length      <= held_length_next;
        running_value    <= running_value_next;
        all_digits       <= all_digits_next;
        value_overflowed <= value_overflowed_next;
        stored_value     <= stored_value_next;
        fresh_flag       <= fresh_flag_next;
        res_valid        <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      frame_accepted <= accepted_next;
    end
  end

  // stored value and flag only change on a transfer, so they hold while stalled
  assign res.valid          = res_valid;
  assign res.current_value  = stored_value;
  assign res.value_fresh    = fresh_flag;
  assign res.frame_accepted = frame_accepted;

endmodule

// ===== hw/rtl/ddfp_checker.sv =====
// Port-level checks for the frame parser, bound to the top level.
// Depends on ddfp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ddfp_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               rx_valid,
  input logic                               rx_ready,
  input logic                               rx_operation,
  input logic                               res_valid,
  input logic                               res_ready,
  input logic signed [ddfp_pkg::VALUE_W-1:0] res_current_value,
  input logic                               res_value_fresh,
  input logic                               res_frame_accepted
);
  import ddfp_pkg::*;

  logic frame_shown;
  logic clear_xfer;

  assign frame_shown = res_valid && res_frame_accepted;
  assign clear_xfer  = rx_valid && rx_ready && (rx_operation == OP_CLEAR);

  // a stalled result stays offered
  `ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid)
  // a taken frame always leaves a fresh, non-negative value
  `ASSERT_SAME(a_frame_fresh, frame_shown, res_value_fresh && !res_current_value[VALUE_W-1])
  // without a fresh value the stored value is the empty marker
  `ASSERT_SAME(a_empty_value, res_valid && !res_value_fresh, res_current_value == VALUE_NONE)
  // a clear transfer shows up next cycle as an empty, unflagged result
  `ASSERT_NEXT(a_clear_result, clear_xfer, res_valid && !res_value_fresh && !res_frame_accepted)

endmodule

bind delimited_decimal_frame_parser_top ddfp_checker u_ddfp_checker (
  .clk                (clk),
  .rst                (rst),
  .rx_valid           (rx.valid),
  .rx_ready           (rx.ready),
  .rx_operation       (rx.operation),
  .res_valid          (res.valid),
  .res_ready          (res.ready),
  .res_current_value  (res.current_value),
  .res_value_fresh    (res.value_fresh),
  .res_frame_accepted (res.frame_accepted)
);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench for delimited_decimal_frame_parser_top: a directed table, then random frames,
// checked against a parser model kept in this file. Depends on ddfp_pkg, ddfp_rx_if,
// ddfp_res_if and the top level.
module tb;
  import ddfp_pkg::*;

  localparam int FRAME_BYTES = BUFFER_BYTES_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int REPORT_MAX  = 10;
  localparam int PHASE_ITEMS = 600;
  localparam int RANDOM_ITEMS = 1750;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic                      fresh;
    logic                      accepted;
  } parse_result_t;

  typedef struct {
    logic              op;
    logic [BYTE_W-1:0] data;
    bit                typed;
    parse_result_t     want;
  } stim_row_t;

  logic clk;
  logic rst;

  ddfp_rx_if  rx ();
  ddfp_res_if res ();

  delimited_decimal_frame_parser_top #(.BUFFER_BYTES(FRAME_BYTES)) dut (
    .clk(clk),
    .rst(rst),
    .rx (rx),
    .res(res)
  );

  // parser model state
  int unsigned               held_len;
  logic [RUN_W-1:0]          run_val;
  bit                        run_digits;
  bit                        run_ovf;
  logic signed [VALUE_W-1:0] last_value;
  logic                      last_fresh;

  parse_result_t pending_results[$];
  stim_row_t     stim_table[$];
  parse_result_t no_want;
  parse_result_t seen_want;

  int src_idle_pct;
  int snk_idle_pct;
  int items_sent;
  int directed_count;
  int frames_stored;
  int clears_seen;
  int mismatches;
  int quiet_cycles;

  always #10 clk = ~clk;

  task restart_frame;
    held_len   = 0;
    run_val    = '0;
    run_digits = 1'b1;
    run_ovf    = 1'b0;
  endtask

  task parse_item(input logic op, input logic [BYTE_W-1:0] b, output parse_result_t r);
    logic [RUN_W+3:0] next_val;
    r.accepted = 1'b0;
    if (op == OP_CLEAR) begin
      last_value = VALUE_NONE;
      last_fresh = 1'b0;
      clears_seen++;
    end else if (b == BYTE_START) begin
      restart_frame();
    end else if (b == BYTE_END) begin
      if (held_len > 0 && run_digits && !run_ovf) begin
        last_value = {1'b0, run_val};
        last_fresh = 1'b1;
        r.accepted = 1'b1;
        frames_stored++;
      end
      restart_frame();
    end else if (held_len < FRAME_BYTES - 1) begin
      held_len++;
      if (b < BYTE_ZERO || b > BYTE_NINE) begin
        run_digits = 1'b0;
      end else if (run_digits && !run_ovf) begin
        next_val = run_val * 10 + (b - BYTE_ZERO);
        // freeze the running value once it would pass 2^31-1
        if (next_val > {4'b0, {RUN_W{1'b1}}}) run_ovf = 1'b1;
        else run_val = next_val[RUN_W-1:0];
      end
    end else begin
      // full frame: drop it together with this byte
      restart_frame();
    end
    r.value = last_value;
    r.fresh = last_fresh;
  endtask

  task add_row(input logic op, input logic [BYTE_W-1:0] data, input bit typed,
               input logic signed [VALUE_W-1:0] value, input logic fresh, input logic acc);
    stim_row_t row;
    row.op             = op;
    row.data           = data;
    row.typed          = typed;
    row.want.value     = value;
    row.want.fresh     = fresh;
    row.want.accepted  = acc;
    stim_table.push_back(row);
  endtask

  task add_digits(input string s);
    int i;
    for (i = 0; i < s.len(); i++) add_row(OP_BYTE, s[i], 1'b0, '0, 1'b0, 1'b0);
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task send_item(input logic op, input logic [BYTE_W-1:0] b, input bit typed,
                 input parse_result_t want);
    parse_result_t model_r;
    while ($urandom_range(99) < src_idle_pct) begin
      rx.valid <= 1'b0;
      @(negedge clk);
    end
    rx.valid     <= 1'b1;
    rx.operation <= op;
    rx.rx_data   <= b;
    do @(posedge clk); while (!rx.ready);
    parse_item(op, b, model_r);
    if (typed) pending_results.push_back(want);
    else pending_results.push_back(model_r);
    items_sent++;
    @(negedge clk);
  endtask

  task send_byte(input logic [BYTE_W-1:0] b);
    send_item(OP_BYTE, b, 1'b0, no_want);
  endtask

  function automatic logic [BYTE_W-1:0] rand_digit();
    return BYTE_ZERO + 8'($urandom_range(9));
  endfunction

  // Hold the sender off until every expected result has come back.
  task drain_results;
    rx.valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task send_random_frame;
    int roll;
    int n;
    int k;
    int cut;
    logic [BYTE_W-1:0] b;
    string lead;
    lead = "21474836";
    roll = $urandom_range(99);
    if (roll < 45) begin
      send_byte(BYTE_START);
      n = ($urandom_range(99) < 70) ? $urandom_range(1, 6) : $urandom_range(7, 12);
      repeat (n) send_byte(rand_digit());
      send_byte(BYTE_END);
    end else if (roll < 55) begin
      // straddle the 31-bit limit
      send_byte(BYTE_START);
      for (k = 0; k < lead.len(); k++) send_byte(lead[k]);
      send_byte(rand_digit());
      send_byte(rand_digit());
      send_byte(BYTE_END);
    end else if (roll < 65) begin
      n   = $urandom_range(1, 8);
      cut = $urandom_range(n - 1);
      send_byte(BYTE_START);
      for (k = 0; k < n; k++) begin
        if (k == cut) begin
          do b = 8'($urandom_range(255)); while (b == BYTE_START || b == BYTE_END);
          send_byte(b);
        end else begin
          send_byte(rand_digit());
        end
      end
      send_byte(BYTE_END);
    end else if (roll < 72) begin
      // lengths around the frame limit, mostly zeros so only the length matters
      send_byte(BYTE_START);
      n = $urandom_range(FRAME_BYTES - 2, FRAME_BYTES + 2);
      repeat (n) send_byte(($urandom_range(9) < 8) ? BYTE_ZERO : rand_digit());
      send_byte(BYTE_END);
    end else if (roll < 80) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
    end else if (roll < 86) begin
      send_item(OP_CLEAR, 8'($urandom_range(255)), 1'b0, no_want);
    end else if (roll < 93) begin
      repeat ($urandom_range(0, 5)) send_byte(rand_digit());
      send_byte(BYTE_END);
    end else begin
      send_byte(BYTE_START);
      repeat ($urandom_range(1, 4)) send_byte(rand_digit());
      send_byte(BYTE_START);
      repeat ($urandom_range(1, 4)) send_byte(rand_digit());
      send_byte(BYTE_END);
    end
  endtask

  task flag_failure(input string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("%0t: %s", $time, msg);
  endtask

  always @(negedge clk) begin
    res.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) begin
      if (pending_results.size() == 0) begin
        flag_failure($sformatf("unexpected result: value %0d fresh %0b frame %0b",
                               res.current_value, res.value_fresh, res.frame_accepted));
      end else begin
        seen_want = pending_results.pop_front();
        if (res.current_value !== seen_want.value || res.value_fresh !== seen_want.fresh ||
            res.frame_accepted !== seen_want.accepted) begin
          flag_failure($sformatf({"result mismatch: expected value %0d fresh %0b frame %0b,",
                                  " got value %0d fresh %0b frame %0b"},
                                 seen_want.value, seen_want.fresh, seen_want.accepted,
                                 res.current_value, res.value_fresh, res.frame_accepted));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((rx.valid && rx.ready) || (res.valid && res.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    rx.valid     = 1'b0;
    rx.operation = OP_BYTE;
    rx.rx_data   = '0;
    src_idle_pct = 28;
    snk_idle_pct = 55;
    items_sent    = 0;
    frames_stored = 0;
    clears_seen   = 0;
    mismatches    = 0;
    no_want       = '{value: '0, fresh: 1'b0, accepted: 1'b0};
    restart_frame();
    last_value = VALUE_NONE;
    last_fresh = 1'b0;

    // empty frame right after reset, clear with ignored data
    add_row(OP_BYTE, BYTE_END, 1'b1, VALUE_NONE, 1'b0, 1'b0);
    add_row(OP_CLEAR, 8'hFF, 1'b1, VALUE_NONE, 1'b0, 1'b0);
    // largest value that fits
    add_digits("2147483647");
    add_row(OP_BYTE, BYTE_END, 1'b1, 32'sh7FFFFFFF, 1'b1, 1'b1);
    // non-digit bytes reject the frame
    add_row(OP_BYTE, 8'h00, 1'b0, '0, 1'b0, 1'b0);
    add_row(OP_BYTE, 8'hFF, 1'b0, '0, 1'b0, 1'b0);
    add_row(OP_BYTE, BYTE_END, 1'b1, 32'sh7FFFFFFF, 1'b1, 1'b0);
    add_row(OP_CLEAR, 8'h00, 1'b1, VALUE_NONE, 1'b0, 1'b0);
    // restart mid-frame, then overflow, then run past the frame limit
    add_row(OP_BYTE, BYTE_NINE, 1'b0, '0, 1'b0, 1'b0);
    add_row(OP_BYTE, BYTE_START, 1'b0, '0, 1'b0, 1'b0);
    add_digits("2147483648");
    add_digits("00000");
    add_digits("7");
    add_digits("5");
    add_row(OP_BYTE, BYTE_END, 1'b1, 32'sd5, 1'b1, 1'b1);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) begin
      send_item(stim_table[i].op, stim_table[i].data, stim_table[i].typed, stim_table[i].want);
    end
    directed_count = items_sent;
    drain_results();

    while (items_sent < directed_count + PHASE_ITEMS) send_random_frame();
    drain_results();
    src_idle_pct = 55;
    snk_idle_pct = 28;
    while (items_sent < directed_count + 2 * PHASE_ITEMS) send_random_frame();
    drain_results();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    while (items_sent < directed_count + RANDOM_ITEMS) send_random_frame();

    rx.valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    repeat (4) @(negedge clk);

    $display("Run covered %0d items (%0d directed, %0d random) under three idle patterns.",
             items_sent, directed_count, items_sent - directed_count);
    $display("Frames stored: %0d, clear requests: %0d, mismatches: %0d.",
             frames_stored, clears_seen, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== delimited_decimal_frame_parser_top.f =====
+incdir+hw/rtl
hw/rtl/ddfp_pkg.sv
hw/rtl/ddfp_rx_if.sv
hw/rtl/ddfp_res_if.sv
hw/rtl/delimited_decimal_frame_parser_top.sv
hw/rtl/ddfp_checker.sv
tb/tb.sv
